@@ rtl/core/tgc_pkg.sv @@
// Shared constants and types for the touch gesture classifier.
package tgc_pkg;

    localparam int unsigned COORD_MAX = 4096;
    localparam int unsigned COORD_W   = 16;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W      = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISTANCE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_NEEDED   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_DISTANCE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 8'd3;
    localparam int unsigned CFG_DATA_W     = 12;

    // Gesture flag bits
    localparam int unsigned FLG_RIGHT   = 0;
    localparam int unsigned FLG_LEFT    = 1;
    localparam int unsigned FLG_SWDOWN  = 2;
    localparam int unsigned FLG_UP      = 3;
    localparam int unsigned FLG_LONG    = 4;
    localparam int unsigned FLG_SHORT   = 5;
    localparam int unsigned FLG_INHIBIT = 6;
    localparam int unsigned FLG_DOWN    = 7;

    localparam logic [7:0] FLAGS_DOWN_ONLY  = 8'h80;
    localparam logic [7:0] FLAGS_INHIBIT    = 8'h40;
    localparam logic [7:0] FLAGS_SHORT      = 8'h20;
    localparam logic [7:0] MASK_NO_SHORT    = 8'hDF;
    localparam logic [7:0] MASK_ACTIVE      = 8'hC0;
    localparam logic [7:0] MASK_GESTURE     = 8'h5F;
    localparam logic [7:0] FLAGS_SW_RIGHT   = 8'h81;
    localparam logic [7:0] FLAGS_SW_LEFT    = 8'h82;
    localparam logic [7:0] FLAGS_SW_DOWN    = 8'h84;
    localparam logic [7:0] FLAGS_SW_UP      = 8'h88;

    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] amount;
        logic       invalid;
    } t_result;

endpackage

@@ rtl/core/touch_gesture_classifier.sv @@
// Touch gesture classifier: one sample in, one flag/amount result out.
//
// Usage:
//   Input stream (s_axis): one request per touch sample. tuser carries the
//   mode (0 touch sample, 1 inhibit request); tdata carries pressed, pos_x
//   and pos_y from bit 0 up. Output stream (m_axis): one result per request,
//   tdata = gesture_flags then move_amount, tuser = invalid mark.
//   Config channel (i_cfg_*): writes step_distance (0), steps_needed (1),
//   swipe_distance (2), long_press_count (3); other indexes are dropped.
//   Always ready; write only while the block is idle.
//   Timing: the result is registered and valid in the cycle after its request is taken.
//   Throughput: one request per cycle while the receiver keeps up. All
//   classification is a single pass of compares and small counters from the
//   accepted request into the result register and the gesture state.
//   Stall: the result register holds while m_axis_tready is low and the
//   input accepts again in the cycle the result is taken, so a stalled
//   receiver backs up into s_axis_tready.
//   Reset (i_rst_n low, synchronous): clears gesture state and output valid,
//   and loads the configuration defaults 5, 8, 40, 100.
module touch_gesture_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // [0] pressed, [16:1] pos_x, [32:17] pos_y
    input  logic [0:0]                    s_axis_tuser,  // [0] mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [7:0] gesture_flags, [15:8] move_amount
    output logic [0:0]                    m_axis_tuser,  // [0] invalid
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tgc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tgc_pkg::*;

    // configuration
    logic [7:0]  r_step_dist;
    logic [3:0]  r_steps_needed;
    logic [11:0] r_swipe_dist;
    logic [7:0]  r_long_cnt;

    // gesture state
    logic [7:0]  r_flags, n_flags;
    logic [3:0]  r_x_steps, n_x_steps;
    logic [3:0]  r_y_steps, n_y_steps;
    logic [7:0]  r_still, n_still;
    logic [15:0] r_last_x, n_last_x;
    logic [15:0] r_last_y, n_last_y;
    logic [15:0] r_anchor_x, n_anchor_x;
    logic [15:0] r_anchor_y, n_anchor_y;

    // result register
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        in_fire;
    logic        in_mode, in_pressed;
    logic [15:0] in_x, in_y;

    assign in_mode    = s_axis_tuser[0];
    assign in_pressed = s_axis_tdata[0];
    assign in_x       = s_axis_tdata[16:1];
    assign in_y       = s_axis_tdata[32:17];

    // output register frees in the cycle it is taken
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.amount, r_out.flags};
    assign m_axis_tuser  = r_out.invalid;

    // per-sample helpers
    logic [7:0]  flags_ns;       // flags with short pulse dropped
    logic [15:0] adx, ady;
    logic        step_x, step_y;
    logic [8:0]  still_sum;
    logic [17:0] dx, dy, ndx, ndy, swipe_s;
    logic        sx_ok, sy_ok, coord_bad;

    always_comb begin
        flags_ns  = r_flags & MASK_NO_SHORT;
        adx       = (r_last_x >= in_x) ? r_last_x - in_x : in_x - r_last_x;
        ady       = (r_last_y >= in_y) ? r_last_y - in_y : in_y - r_last_y;
        step_x    = adx >= {8'd0, r_step_dist};
        step_y    = ady >= {8'd0, r_step_dist};
        still_sum = {1'b0, r_still} + {8'd0, !step_x} + {8'd0, !step_y};
        dx        = {2'b00, in_x} - {2'b00, r_anchor_x};
        dy        = {2'b00, in_y} - {2'b00, r_anchor_y};
        ndx       = -dx;
        ndy       = -dy;
        swipe_s   = {6'd0, r_swipe_dist};
        // step counts before this sample's advance decide a swipe
        sx_ok     = r_x_steps >= r_steps_needed;
        sy_ok     = r_y_steps >= r_steps_needed;
        coord_bad = (in_x > 16'(COORD_MAX)) || (in_y > 16'(COORD_MAX));
    end

    always_comb begin
        n_flags    = r_flags;
        n_x_steps  = r_x_steps;
        n_y_steps  = r_y_steps;
        n_still    = r_still;
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_anchor_x = r_anchor_x;
        n_anchor_y = r_anchor_y;
        n_out      = '{flags: 8'd0, amount: 8'd0, invalid: 1'b0};

        if (in_mode) begin
            n_flags   = FLAGS_INHIBIT;
            n_x_steps = '0;
            n_y_steps = '0;
            n_still   = '0;
        end else if (in_pressed) begin
            n_flags = flags_ns;
            if (flags_ns[FLG_DOWN]) begin
                if (step_x && r_x_steps < r_steps_needed) n_x_steps = r_x_steps + 4'd1;
                if (step_y && r_y_steps < r_steps_needed) n_y_steps = r_y_steps + 4'd1;
                n_still = still_sum[8] ? 8'hFF : still_sum[7:0];
            end
            n_last_x = in_x;
            n_last_y = in_y;
            priority if ((flags_ns & MASK_ACTIVE) == 8'd0) begin
                if (coord_bad) begin
                    n_out.invalid = 1'b1;
                end else begin
                    n_flags    = FLAGS_DOWN_ONLY;
                    n_x_steps  = '0;
                    n_y_steps  = '0;
                    n_still    = '0;
                    n_anchor_x = in_x;
                    n_anchor_y = in_y;
                end
            end else if ((flags_ns & MASK_GESTURE) != 8'd0) begin
                n_anchor_x = in_x;
                n_anchor_y = in_y;
            end else if (!dx[17] && dx >= swipe_s && sx_ok) begin
                n_flags[FLG_RIGHT] = 1'b1;
            end else if (!ndx[17] && ndx >= swipe_s && sx_ok) begin
                n_flags[FLG_LEFT] = 1'b1;
            end else if (!dy[17] && dy >= swipe_s && sy_ok) begin
                n_flags[FLG_SWDOWN] = 1'b1;
            end else if (!ndy[17] && ndy >= swipe_s && sy_ok) begin
                n_flags[FLG_UP] = 1'b1;
            end else if (n_still > r_long_cnt) begin
                n_flags[FLG_LONG] = 1'b1;
            end else begin
                // still held, nothing classified yet
            end
            // amount against the anchor as left by this sample
            if (!n_out.invalid) begin
                unique case (n_flags)
                    FLAGS_SW_RIGHT: n_out.amount = 8'(in_x - n_anchor_x);
                    FLAGS_SW_LEFT:  n_out.amount = 8'(n_anchor_x - in_x);
                    FLAGS_SW_DOWN:  n_out.amount = 8'(in_y - n_anchor_y);
                    FLAGS_SW_UP:    n_out.amount = 8'(n_anchor_y - in_y);
                    default:        n_out.amount = 8'd0;
                endcase
            end
        end else begin
            // release: clears flags and counters, short pulse after a plain press
            n_flags   = 8'd0;
            n_x_steps = '0;
            n_y_steps = '0;
            n_still   = '0;
            if (flags_ns[FLG_DOWN] && (flags_ns & MASK_GESTURE) == 8'd0) begin
                n_flags      = FLAGS_SHORT;
                n_out.amount = 8'd1;
            end
        end
        n_out.flags = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_dist    <= 8'd5;
            r_steps_needed <= 4'd8;
            r_swipe_dist   <= 12'd40;
            r_long_cnt     <= 8'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP_DISTANCE:  r_step_dist    <= i_cfg_data[7:0];
                CFG_STEPS_NEEDED:   r_steps_needed <= i_cfg_data[3:0];
                CFG_SWIPE_DISTANCE: r_swipe_dist   <= i_cfg_data;
                CFG_LONG_PRESS:     r_long_cnt     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_x_steps   <= '0;
            r_y_steps   <= '0;
            r_still     <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_anchor_x  <= '0;
            r_anchor_y  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_flags     <= n_flags;
                r_x_steps   <= n_x_steps;
                r_y_steps   <= n_y_steps;
                r_still     <= n_still;
                r_last_x    <= n_last_x;
                r_last_y    <= n_last_y;
                r_anchor_x  <= n_anchor_x;
                r_anchor_y  <= n_anchor_y;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // an inhibit request always yields inhibit-only flags
    a_inhibit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && in_mode |=> r_out_valid && r_out.flags == FLAGS_INHIBIT)
        else $error("inhibit request did not produce inhibit flags");

    // a rejected first press never reports an active gesture
    a_invalid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.invalid |-> (r_out.flags & MASK_ACTIVE) == 8'd0
            && r_out.amount == 8'd0)
        else $error("invalid result with active flags or amount");

    // short pulse carries amount one and nothing else
    a_short_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.flags[FLG_SHORT] |-> r_out.flags == FLAGS_SHORT
            && r_out.amount == 8'd1)
        else $error("malformed short press result");
`endif

endmodule

@@ dv/tgc_scoreboard_pkg.sv @@
// Gesture predictor and in-order result scoreboard for the touch gesture classifier.
package tgc_scoreboard_pkg;
    import tgc_pkg::*;

    localparam bit MODE_TOUCH   = 1'b0;
    localparam bit MODE_INHIBIT = 1'b1;

    class tgc_scoreboard;
        // register copies
        logic [7:0]  step_dist;
        logic [3:0]  steps_req;
        logic [11:0] swipe_dist;
        logic [7:0]  long_cnt;
        // gesture state
        logic [7:0]  flags;
        logic [3:0]  x_steps;
        logic [3:0]  y_steps;
        logic [7:0]  still_cnt;
        logic [15:0] last_x;
        logic [15:0] last_y;
        logic [15:0] anchor_x;
        logic [15:0] anchor_y;

        t_result     expected_q[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            reset_state();
        endfunction

        function void clear_gesture();
            flags     = '0;
            x_steps   = '0;
            y_steps   = '0;
            still_cnt = '0;
        endfunction

        function void reset_state();
            step_dist  = 8'd5;
            steps_req  = 4'd8;
            swipe_dist = 12'd40;
            long_cnt   = 8'd100;
            clear_gesture();
            last_x   = '0;
            last_y   = '0;
            anchor_x = '0;
            anchor_y = '0;
            expected_q.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STEP_DISTANCE:  step_dist  = data[7:0];
                CFG_STEPS_NEEDED:   steps_req  = data[3:0];
                CFG_SWIPE_DISTANCE: swipe_dist = data[11:0];
                CFG_LONG_PRESS:     long_cnt   = data[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned gap(logic [15:0] a, logic [15:0] b);
            return (a >= b) ? int'(a - b) : int'(b - a);
        endfunction

        function void bump_still();
            if (still_cnt != 8'hFF) still_cnt++;
        endfunction

        // Advance the gesture state by one request and queue the result it yields.
        function void note_request(bit mode, bit pressed, logic [15:0] x, logic [15:0] y);
            t_result     res;
            logic [3:0]  sx;
            logic [3:0]  sy;
            logic [15:0] diff;
            int          dx;
            int          dy;
            int          need;
            bit          bad;
            bit          short_hit;
            res = '0;
            sx  = '0;
            sy  = '0;
            bad = 1'b0;
            if (mode == MODE_INHIBIT) begin
                clear_gesture();
                flags = FLAGS_INHIBIT;
            end else begin
                flags &= MASK_NO_SHORT;
                if (pressed) begin
                    if (flags[FLG_DOWN]) begin
                        sx = x_steps;
                        sy = y_steps;
                        if (gap(last_x, x) >= step_dist) begin
                            if (x_steps < steps_req) x_steps++;
                        end else begin
                            bump_still();
                        end
                        if (gap(last_y, y) >= step_dist) begin
                            if (y_steps < steps_req) y_steps++;
                        end else begin
                            bump_still();
                        end
                    end
                    last_x = x;
                    last_y = y;
                    dx     = int'(x) - int'(anchor_x);
                    dy     = int'(y) - int'(anchor_y);
                    need   = int'(swipe_dist);
                    if ((flags & MASK_ACTIVE) == '0) begin
                        if (x > COORD_MAX || y > COORD_MAX) begin
                            bad = 1'b1;
                        end else begin
                            clear_gesture();
                            flags    = FLAGS_DOWN_ONLY;
                            anchor_x = x;
                            anchor_y = y;
                        end
                    end else if ((flags & MASK_GESTURE) != '0) begin
                        anchor_x = x;
                        anchor_y = y;
                    end else if (dx >= need && sx >= steps_req) begin
                        flags[FLG_RIGHT] = 1'b1;
                    end else if (-dx >= need && sx >= steps_req) begin
                        flags[FLG_LEFT] = 1'b1;
                    end else if (dy >= need && sy >= steps_req) begin
                        flags[FLG_SWDOWN] = 1'b1;
                    end else if (-dy >= need && sy >= steps_req) begin
                        flags[FLG_UP] = 1'b1;
                    end else if (still_cnt > long_cnt) begin
                        flags[FLG_LONG] = 1'b1;
                    end
                    if (!bad) begin
                        case (flags)
                            FLAGS_SW_RIGHT: diff = x - anchor_x;
                            FLAGS_SW_LEFT:  diff = anchor_x - x;
                            FLAGS_SW_DOWN:  diff = y - anchor_y;
                            FLAGS_SW_UP:    diff = anchor_y - y;
                            default:        diff = '0;
                        endcase
                        res.amount = diff[7:0];
                    end
                end else begin
                    short_hit = flags[FLG_DOWN] && ((flags & MASK_GESTURE) == '0);
                    clear_gesture();
                    if (short_hit) begin
                        flags |= FLAGS_SHORT;
                        res.amount = 8'd1;
                    end
                end
            end
            res.flags   = flags;
            res.invalid = bad;
            expected_q.push_back(res);
        endfunction

        function void compare_field(longint unsigned now, string name, logic [7:0] want,
                                    logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0d ns: %s mismatch, expected 0x%02h, actual 0x%02h",
                         now, name, want, got);
            end
        endfunction

        function void check_result(longint unsigned now, logic [7:0] f, logic [7:0] a,
                                   logic inv);
            t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display({"%0d ns: result with nothing expected, expected none, ",
                          "actual 0x%02h/0x%02h/%0b"}, now, f, a, inv);
                return;
            end
            want = expected_q.pop_front();
            compare_field(now, "gesture_flags", want.flags, f);
            compare_field(now, "move_amount", want.amount, a);
            compare_field(now, "invalid", {7'd0, want.invalid}, {7'd0, inv});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

@@ dv/tb_touch_gesture_classifier.sv @@
// Self-checking testbench for the touch gesture classifier.
module tb_touch_gesture_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import tgc_pkg::*;
    import tgc_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned ITEM_TARGET  = 600;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_TICKS = 3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;   // [0] pressed, [16:1] pos_x, [32:17] pos_y
    logic [0:0]            s_axis_tuser;   // [0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // [7:0] gesture_flags, [15:8] move_amount
    logic [0:0]            m_axis_tuser;   // [0] invalid
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tgc_scoreboard gest_sb = new();

    bit          long_hold;   // asks the receiver for one long hold-off
    bit          quiet;       // no idling on either side
    int unsigned sent;        // accepted requests so far
    int unsigned cycles;
    int          cur_step;    // step distance in force, used to size the moves

    touch_gesture_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: ends a hung run.
    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Monitors sample at the edge, before the block's registers move.
    // Result first: a result on this edge never belongs to a request taken on it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            gest_sb.check_result($time, m_axis_tdata[7:0], m_axis_tdata[15:8],
                                 m_axis_tuser[0]);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            gest_sb.note_request(s_axis_tuser[0], s_axis_tdata[0], s_axis_tdata[16:1],
                                 s_axis_tdata[32:17]);
    end

    // Receiver: random stall bursts, ready stretches, and one long hold-off on demand.
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                // counted here so the sender keeps pushing and the block backs up
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic int clip16(int v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    // One request on the input stream; returns on the edge that takes it.
    // tvalid stays high afterwards so a following request goes out back to back.
    task automatic send_req(bit mode, bit pressed, logic [15:0] x, logic [15:0] y);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'd0, y, x, pressed};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Stop offering and wait until every expected result is in.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (gest_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Leaves i_cfg_valid high; the caller lowers it after the last write.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        gest_sb.write_reg(idx, data);
    endtask

    // Full register set, plus a write to an unmapped index that must be dropped.
    // With junk set, bits above each register's width are filled at random.
    task automatic configure(int sd, int sn, int sw, int lp, bit junk);
        int hi8;
        int hi4;
        hi8 = junk ? $urandom_range(1, 15) : 0;
        hi4 = junk ? $urandom_range(1, 255) : 0;
        write_cfg(CFG_STEP_DISTANCE, CFG_DATA_W'((hi8 << 8) | sd));
        write_cfg(CFG_STEPS_NEEDED, CFG_DATA_W'((hi4 << 4) | sn));
        write_cfg(CFG_SWIPE_DISTANCE, CFG_DATA_W'(sw));
        write_cfg(CFG_LONG_PRESS, CFG_DATA_W'((hi8 << 8) | lp));
        write_cfg(CFG_IDX_W'($urandom_range(CFG_LONG_PRESS + 1, 255)),
                  CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        cur_step = sd & 8'hFF;
    endtask

    // Press at a start point, two moves of 30 along one axis, release.
    task automatic swipe_probe(int ux, int uy);
        send_req(MODE_TOUCH, 1'b1, 16'd1000, 16'd1000);
        send_req(MODE_TOUCH, 1'b1, 16'(1000 + 30 * ux), 16'(1000 + 30 * uy));
        send_req(MODE_TOUCH, 1'b1, 16'(1000 + 60 * ux), 16'(1000 + 60 * uy));
        send_req(MODE_TOUCH, 1'b0, 16'd0, 16'd0);
    endtask

    // A well-formed touch: press, a run of samples heading one way (or staying
    // put), release. A few starts are off-panel and a few inhibits cut in.
    task automatic run_gesture();
        int x;
        int y;
        int ux;
        int uy;
        int mag;
        int len;
        int dir;
        int jx;
        int jy;
        int i;
        x  = $urandom_range(0, COORD_MAX);
        y  = $urandom_range(0, COORD_MAX);
        ux = 0;
        uy = 0;
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) x = $urandom_range(COORD_MAX + 1, 65535);
            else y = $urandom_range(COORD_MAX + 1, 65535);
        end
        dir = $urandom_range(0, 4);
        case (dir)
            0: ux = 1;
            1: ux = -1;
            2: uy = 1;
            3: uy = -1;
            default: ;
        endcase
        len = $urandom_range(1, 20);
        if (dir == 4 && $urandom_range(0, 2) == 0) len = $urandom_range(20, 140);
        send_req(MODE_TOUCH, 1'b1, 16'(x), 16'(y));
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 39) == 0)
                send_req(MODE_INHIBIT, 1'($urandom), 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 4) == 0)
                mag = (cur_step == 0) ? 0 : $urandom_range(0, cur_step - 1);
            else
                mag = cur_step + $urandom_range(0, 8);
            jx = $urandom_range(0, 2);
            jy = $urandom_range(0, 2);
            x  = clip16(x + ux * mag + jx - 1);
            y  = clip16(y + uy * mag + jy - 1);
            send_req(MODE_TOUCH, 1'b1, 16'(x), 16'(y));
        end
        send_req(MODE_TOUCH, 1'b0, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        int unsigned ph;
        int unsigned phase_end;
        long_hold     = 1'b0;
        quiet         = 1'b0;
        sent          = 0;
        cur_step      = 5;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset defaults: inhibit, release with nothing down,
        // off-panel first presses, edge-of-panel press and short tap,
        // inhibit while held, a press under it, then the release that lifts it.
        send_req(MODE_INHIBIT, 1'b0, 16'd0, 16'd0);
        send_req(MODE_TOUCH, 1'b0, 16'hFFFF, 16'hFFFF);
        send_req(MODE_TOUCH, 1'b1, 16'hFFFF, 16'h0000);
        send_req(MODE_TOUCH, 1'b1, 16'h0000, 16'(COORD_MAX + 1));
        send_req(MODE_TOUCH, 1'b1, 16'(COORD_MAX), 16'(COORD_MAX));
        send_req(MODE_TOUCH, 1'b0, 16'd0, 16'd0);
        send_req(MODE_TOUCH, 1'b1, 16'd0, 16'd0);
        send_req(MODE_INHIBIT, 1'b1, 16'hA5A5, 16'h5A5A);
        send_req(MODE_TOUCH, 1'b1, 16'd5, 16'd5);
        send_req(MODE_TOUCH, 1'b0, 16'd0, 16'd0);

        // Directed swipes: one step per axis is enough, long press out of reach.
        drain();
        configure(5, 1, 20, 255, 1'b0);
        swipe_probe(1, 0);
        swipe_probe(-1, 0);
        swipe_probe(0, 1);
        swipe_probe(0, -1);

        // Random phases, each under its own register setting.
        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: configure(5, 8, 40, 100, 1'b0);
                1: configure(1, 15, 4095, 255, 1'b0);
                2: configure(0, 0, 0, 0, 1'b0);
                3: configure(255, 2, 100, 254, 1'b1);
                default: configure($urandom_range(1, 30), $urandom_range(0, 6),
                                   $urandom_range(0, 200), $urandom_range(0, 60), 1'b1);
            endcase
            if (ph == 1) long_hold = 1'b1;
            if (ph == PHASES - 1) quiet = 1'b1;
            phase_end = sent + ITEM_TARGET / PHASES;
            while (sent < phase_end) begin
                if ($urandom_range(0, 6) == 0)
                    send_req(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
                else
                    run_gesture();
            end
        end

        drain();
        if (gest_sb.mismatches == 0 && gest_sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
